// File: design/sorted_polynomial_term_accumulator_unit_assert.svh
// Assertion macros used by the accumulator top level.
`ifndef SORTED_POLYNOMIAL_TERM_ACCUMULATOR_UNIT_ASSERT_SVH
`define SORTED_POLYNOMIAL_TERM_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SPTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPTA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SPTA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/spta_pkg.sv
// Types and constants of the sorted polynomial term accumulator.
package spta_pkg;

	localparam int EXP_W  = 16;
	localparam int COEF_W = 32;

	typedef enum logic {
		FUNC_ADD  = 1'b0,
		FUNC_READ = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		STAT_INSERTED = 3'd0,
		STAT_MERGED   = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_READ     = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_MERGE,
		OP_ROTATE
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} ctl_state_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t                  op;
		logic signed [COEF_W-1:0]  coef;
		logic signed [EXP_W-1:0]   exp;
	} cell_cmd_t;

	// What one cell shows to its neighbours and to the controller.
	typedef struct packed {
		logic                      valid;
		logic                      gt;
		logic                      eq;
		logic signed [EXP_W-1:0]   exp;
		logic signed [COEF_W-1:0]  coef;
	} cell_link_t;

endpackage

// File: design/spta_cell.sv
// One term cell of the sorted chain: compare, shift-in, merge and rotate.
module spta_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spta_pkg::cell_cmd_t    cmd,
	input  spta_pkg::cell_link_t   lft,
	input  spta_pkg::cell_link_t   rgt,
	input  spta_pkg::cell_link_t   head,
	output spta_pkg::cell_link_t   link
);

	logic                                  valid_q;
	logic signed [spta_pkg::EXP_W-1:0]     exp_q;
	logic signed [spta_pkg::COEF_W-1:0]    coef_q;
	logic                                  valid_d;
	logic signed [spta_pkg::EXP_W-1:0]     exp_d;
	logic signed [spta_pkg::COEF_W-1:0]    coef_d;
	logic                                  gt;
	logic                                  eq;

	assign gt = valid_q && ($signed(exp_q) > $signed(cmd.exp));
	assign eq = valid_q && ($signed(exp_q) == $signed(cmd.exp));

	assign link.valid = valid_q;
	assign link.gt    = gt;
	assign link.eq    = eq;
	assign link.exp   = exp_q;
	assign link.coef  = coef_q;

	always_comb begin
		valid_d = valid_q;
		exp_d   = exp_q;
		coef_d  = coef_q;
		case (cmd.op)
			spta_pkg::OP_INSERT: begin
				// The first cell not holding a larger exponent takes the new term,
				// every cell behind it takes its left neighbour's term.
				if (!gt) begin
					if (lft.gt) begin
						valid_d = 1'b1;
						exp_d   = cmd.exp;
						coef_d  = cmd.coef;
					end else begin
						valid_d = lft.valid;
						exp_d   = lft.exp;
						coef_d  = lft.coef;
					end
				end
			end
			spta_pkg::OP_MERGE: begin
				if (eq) begin
					coef_d = coef_q + cmd.coef;
				end
			end
			spta_pkg::OP_ROTATE: begin
				// The last valid cell closes the ring by taking the head term.
				if (rgt.valid) begin
					exp_d  = rgt.exp;
					coef_d = rgt.coef;
				end else if (valid_q) begin
					exp_d  = head.exp;
					coef_d = head.coef;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		exp_q  <= exp_d;
		coef_q <= coef_d;
	end

endmodule

// File: design/spta_ctrl.sv
// Controller: handshakes, term count, read-out sequencing and result register.
module spta_ctrl #(
	parameter int MAX_TERMS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic signed [spta_pkg::COEF_W-1:0] coefficient,
	input  logic signed [spta_pkg::EXP_W-1:0]  exponent,
	input  logic                              any_eq,
	input  spta_pkg::cell_link_t              head,
	output spta_pkg::cell_cmd_t               cmd,
	output logic                              busy,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic signed [spta_pkg::COEF_W-1:0] coefficient_out,
	output logic signed [spta_pkg::EXP_W-1:0]  exponent_out,
	output logic                              last
);

	localparam int CW = $clog2(MAX_TERMS + 1);

	spta_pkg::ctl_state_t                  state_q, state_d;
	logic [CW-1:0]                         count_q, count_d;
	logic [CW-1:0]                         rem_q, rem_d;
	logic                                  out_valid_q;
	spta_pkg::status_t                     status_q, status_d;
	logic signed [spta_pkg::COEF_W-1:0]    coef_out_q, coef_out_d;
	logic signed [spta_pkg::EXP_W-1:0]     exp_out_q, exp_out_d;
	logic                                  last_q, last_d;
	logic                                  load;
	logic                                  out_free;
	logic                                  full;

	assign out_free = !out_valid_q || !out_stall;
	assign full     = (count_q == CW'(MAX_TERMS));

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		load       = 1'b0;
		status_d   = status_q;
		coef_out_d = '0;
		exp_out_d  = '0;
		last_d     = 1'b1;
		in_stall   = 1'b1;
		cmd.op     = spta_pkg::OP_HOLD;
		cmd.coef   = coefficient;
		cmd.exp    = exponent;
		case (state_q)
			spta_pkg::ST_IDLE: begin
				in_stall = !out_free;
				if (in_valid && out_free) begin
					if (func == spta_pkg::FUNC_ADD) begin
						load = 1'b1;
						if (any_eq) begin
							cmd.op   = spta_pkg::OP_MERGE;
							status_d = spta_pkg::STAT_MERGED;
						end else if (full) begin
							status_d = spta_pkg::STAT_FULL;
						end else begin
							cmd.op   = spta_pkg::OP_INSERT;
							status_d = spta_pkg::STAT_INSERTED;
							count_d  = count_q + CW'(1);
						end
					end else if (count_q == '0) begin
						load     = 1'b1;
						status_d = spta_pkg::STAT_EMPTY;
					end else begin
						rem_d   = count_q;
						state_d = spta_pkg::ST_READ;
					end
				end
			end
			spta_pkg::ST_READ: begin
				if (out_free) begin
					// Emit the head term and turn the ring one place.
					load       = 1'b1;
					cmd.op     = spta_pkg::OP_ROTATE;
					status_d   = spta_pkg::STAT_READ;
					coef_out_d = head.coef;
					exp_out_d  = head.exp;
					last_d     = (rem_q == CW'(1));
					rem_d      = rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_d = spta_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = spta_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spta_pkg::ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q   <= status_d;
			coef_out_q <= coef_out_d;
			exp_out_q  <= exp_out_d;
			last_q     <= last_d;
		end
	end

	assign busy            = (state_q == spta_pkg::ST_READ);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign coefficient_out = coef_out_q;
	assign exponent_out    = exp_out_q;
	assign last            = last_q;

endmodule

// File: design/sorted_polynomial_term_accumulator_unit.sv
// Top level of the sorted polynomial term accumulator: cell chain and controller.
//
//  Channel | Handshake            | Beat contents
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | func, coefficient, exponent
//  output  | out_valid / out_stall| status, coefficient_out, exponent_out, last
//
// Unless the output stalls, an add beat (insert, merge or drop) is taken every
// cycle with its result registered for the next cycle, and a read-out, once in
// the read state, streams one term per cycle from the head cell while the chain
// rotates, holding the input. A stalled output holds the result register and the
// input with it. Reset empties the chain by clearing the cell valid bits.
module sorted_polynomial_term_accumulator_unit #(
	parameter int MAX_TERMS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic signed [spta_pkg::COEF_W-1:0] coefficient,
	input  logic signed [spta_pkg::EXP_W-1:0]  exponent,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic signed [spta_pkg::COEF_W-1:0] coefficient_out,
	output logic signed [spta_pkg::EXP_W-1:0]  exponent_out,
	output logic                              last
);

	`include "sorted_polynomial_term_accumulator_unit_assert.svh"

	spta_pkg::cell_cmd_t   cmd;
	spta_pkg::cell_link_t  links [MAX_TERMS];
	spta_pkg::cell_link_t  lft_edge;
	spta_pkg::cell_link_t  rgt_edge;
	logic [MAX_TERMS-1:0]  vld;
	logic [MAX_TERMS-1:0]  eqv;
	logic [MAX_TERMS-2:0]  ord_ok;
	logic                  any_eq;
	logic                  busy;

	// The front of the chain behaves as if a larger exponent stood before it.
	always_comb begin
		lft_edge    = '0;
		lft_edge.gt = 1'b1;
		rgt_edge    = '0;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TERMS; gi++) begin : g_cell
			spta_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.lft    ((gi == 0) ? lft_edge : links[(gi == 0) ? 0 : gi - 1]),
				.rgt    ((gi == MAX_TERMS - 1) ? rgt_edge
				         : links[(gi == MAX_TERMS - 1) ? gi : gi + 1]),
				.head   (links[0]),
				.link   (links[gi])
			);
			assign vld[gi] = links[gi].valid;
			assign eqv[gi] = links[gi].eq;
		end
		for (gi = 0; gi < MAX_TERMS - 1; gi++) begin : g_ord
			assign ord_ok[gi] = !links[gi + 1].valid
				|| ($signed(links[gi].exp) > $signed(links[gi + 1].exp));
		end
	endgenerate

	assign any_eq = |eqv;

	spta_ctrl #(
		.MAX_TERMS (MAX_TERMS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.coefficient     (coefficient),
		.exponent        (exponent),
		.any_eq          (any_eq),
		.head            (links[0]),
		.cmd             (cmd),
		.busy            (busy),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.coefficient_out (coefficient_out),
		.exponent_out    (exponent_out),
		.last            (last)
	);

	// Stored terms always form a packed prefix of the chain.
	`SPTA_ASSERT_NOW(a_valid_prefix, clk, arst_n, 1'b1, ((vld + 1'b1) & vld) == '0)
	// Outside a read-out the chain is strictly descending by exponent.
	`SPTA_ASSERT_NOW(a_sorted, clk, arst_n, !busy, &ord_ok)
	`SPTA_ASSERT_NEXT(a_drop_on_full, clk, arst_n,
		in_valid && !in_stall && !func && !any_eq && vld[MAX_TERMS-1],
		out_valid && status == spta_pkg::STAT_FULL && $stable(vld))
	`SPTA_ASSERT_NEXT(a_merge_keeps_count, clk, arst_n,
		in_valid && !in_stall && !func && any_eq,
		$stable(vld) && status == spta_pkg::STAT_MERGED)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the sorted polynomial term accumulator unit.
`timescale 1ns / 1ps

module tb_top;

	localparam int TERMS      = 16;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_AT    = 120;
	localparam int HOLD_LEN   = 80;
	localparam int CALM_FROM  = 280;
	localparam int CALM_TO    = 360;
	localparam int RANDOM_BEATS = 436;

	typedef struct {
		spta_pkg::func_t                    op;
		logic signed [spta_pkg::COEF_W-1:0] coef;
		logic signed [spta_pkg::EXP_W-1:0]  exp;
	} term_beat_t;

	typedef struct {
		spta_pkg::status_t                  status;
		logic signed [spta_pkg::COEF_W-1:0] coef;
		logic signed [spta_pkg::EXP_W-1:0]  exp;
		logic                               last;
	} term_result_t;

	logic                               clk         = 1'b0;
	logic                               arst_n      = 1'b0;
	logic                               in_valid    = 1'b0;
	logic                               in_stall;
	logic                               func        = spta_pkg::FUNC_ADD;
	logic signed [spta_pkg::COEF_W-1:0] coefficient = '0;
	logic signed [spta_pkg::EXP_W-1:0]  exponent    = '0;
	logic                               out_valid;
	logic                               out_stall   = 1'b0;
	logic [2:0]                         status;
	logic signed [spta_pkg::COEF_W-1:0] coefficient_out;
	logic signed [spta_pkg::EXP_W-1:0]  exponent_out;
	logic                               last;

	// Shadow of the term table, kept sorted by descending exponent.
	logic signed [spta_pkg::EXP_W-1:0]  shadow_exps [TERMS];
	logic signed [spta_pkg::COEF_W-1:0] shadow_coefs [TERMS];
	int                                 shadow_count = 0;

	term_beat_t   pending_beats [$];
	term_result_t expected_terms [$];
	logic         in_taken    = 1'b0;
	int           beats_taken = 0;
	int           n_errors    = 0;
	int           cycle_count = 0;
	int           hold_left   = 0;
	logic         hold_done   = 1'b0;
	logic         calm;

	assign calm = (beats_taken >= CALM_FROM) && (beats_taken < CALM_TO);

	sorted_polynomial_term_accumulator_unit #(
		.MAX_TERMS(TERMS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.coefficient(coefficient),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.coefficient_out(coefficient_out),
		.exponent_out(exponent_out),
		.last(last)
	);

	always #1 clk = ~clk;

	task automatic predict_terms(input term_beat_t b);
		int           pos;
		term_result_t r;
		r = '{spta_pkg::STAT_INSERTED, '0, '0, 1'b1};
		if (b.op == spta_pkg::FUNC_READ) begin
			if (shadow_count == 0) begin
				r.status = spta_pkg::STAT_EMPTY;
				expected_terms.push_back(r);
			end else begin
				for (int i = 0; i < shadow_count; i++) begin
					r.status = spta_pkg::STAT_READ;
					r.coef   = shadow_coefs[i];
					r.exp    = shadow_exps[i];
					r.last   = (i == shadow_count - 1);
					expected_terms.push_back(r);
				end
			end
		end else begin
			pos = 0;
			while (pos < shadow_count && shadow_exps[pos] > b.exp)
				pos++;
			if (pos < shadow_count && shadow_exps[pos] == b.exp) begin
				shadow_coefs[pos] = shadow_coefs[pos] + b.coef;
				r.status = spta_pkg::STAT_MERGED;
			end else if (shadow_count >= TERMS) begin
				r.status = spta_pkg::STAT_FULL;
			end else begin
				for (int j = shadow_count; j > pos; j--) begin
					shadow_exps[j]  = shadow_exps[j-1];
					shadow_coefs[j] = shadow_coefs[j-1];
				end
				shadow_exps[pos]  = b.exp;
				shadow_coefs[pos] = b.coef;
				shadow_count++;
				r.status = spta_pkg::STAT_INSERTED;
			end
			expected_terms.push_back(r);
		end
	endtask

	task automatic queue_beat(input spta_pkg::func_t op,
			input logic [spta_pkg::COEF_W-1:0] c,
			input logic [spta_pkg::EXP_W-1:0] e);
		term_beat_t b;
		b.op   = op;
		b.coef = c;
		b.exp  = e;
		pending_beats.push_back(b);
	endtask

	task automatic flag_mismatch(input string field, input longint want, input longint got);
		n_errors++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// Input beats are predicted at the edge that accepts them.
	always @(posedge clk) begin
		term_beat_t b;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			b.op   = spta_pkg::func_t'(func);
			b.coef = coefficient;
			b.exp  = exponent;
			predict_terms(b);
			beats_taken++;
		end
	end

	always @(negedge clk) begin
		term_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
				nxt = pending_beats.pop_front();
				in_valid    <= 1'b1;
				func        <= nxt.op;
				coefficient <= nxt.coef;
				exponent    <= nxt.exp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Once during the run the receiver holds off long enough for the block to back up.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && beats_taken >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 10);
		end
	end

	always @(posedge clk) begin
		term_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_terms.size() == 0) begin
				flag_mismatch("unexpected result status", -1, status);
			end else begin
				want = expected_terms.pop_front();
				if (status !== want.status)
					flag_mismatch("status", want.status, status);
				if (coefficient_out !== want.coef)
					flag_mismatch("coefficient_out", want.coef, coefficient_out);
				if (exponent_out !== want.exp)
					flag_mismatch("exponent_out", want.exp, exponent_out);
				if (last !== want.last)
					flag_mismatch("last", want.last, last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_CAP) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		shortint                      fill_exps [12];
		shortint                      known_exps [$];
		int                           pick;
		logic [31:0]                  rnd;
		logic [spta_pkg::EXP_W-1:0]   e;

		fill_exps = '{100, -100, 5, 20000, -20000, 1, -2, 300, -7, 16384, -16385, 42};

		// Directed beats: empty read-out, field extremes, merge to zero,
		// wrap-around, a full table, a dropped term and a merge on a full table.
		queue_beat(spta_pkg::FUNC_READ, 32'h0, 16'h0);
		queue_beat(spta_pkg::FUNC_ADD, 32'd5, 16'd0);
		queue_beat(spta_pkg::FUNC_ADD, 32'h7FFF_FFFF, 16'h7FFF);
		queue_beat(spta_pkg::FUNC_ADD, 32'h8000_0000, 16'h8000);
		queue_beat(spta_pkg::FUNC_ADD, -32'sd5, 16'd0);
		queue_beat(spta_pkg::FUNC_READ, 32'hFFFF_FFFF, 16'hFFFF);
		queue_beat(spta_pkg::FUNC_ADD, 32'd1, 16'h7FFF);
		queue_beat(spta_pkg::FUNC_ADD, 32'hFFFF_FFFF, 16'hFFFF);
		queue_beat(spta_pkg::FUNC_ADD, 32'hFFFF_FFFF, 16'h8000);
		known_exps = '{0, 32767, -32768, -1};
		foreach (fill_exps[i]) begin
			queue_beat(spta_pkg::FUNC_ADD, $urandom, fill_exps[i]);
			known_exps.push_back(fill_exps[i]);
		end
		queue_beat(spta_pkg::FUNC_ADD, 32'd7, -16'sd3);
		queue_beat(spta_pkg::FUNC_ADD, 32'd3, 16'd100);
		queue_beat(spta_pkg::FUNC_READ, 32'h0, 16'h0);

		// The table cannot be emptied, so the random part is merges into stored terms,
		// near misses and wild exponents (dropped if new), and read-outs.
		for (int k = 0; k < RANDOM_BEATS; k++) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				rnd = $urandom;
				queue_beat(spta_pkg::FUNC_READ, $urandom, rnd[spta_pkg::EXP_W-1:0]);
			end else if (pick < 70) begin
				e = known_exps[$urandom_range(known_exps.size() - 1)];
				queue_beat(spta_pkg::FUNC_ADD, $urandom, e);
			end else if (pick < 80) begin
				e = known_exps[$urandom_range(known_exps.size() - 1)];
				e = $urandom_range(1) ? e + 16'd1 : e - 16'd1;
				queue_beat(spta_pkg::FUNC_ADD, $urandom, e);
			end else begin
				rnd = $urandom;
				queue_beat(spta_pkg::FUNC_ADD, $urandom, rnd[spta_pkg::EXP_W-1:0]);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_beats.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_terms.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (n_errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
